// ----- hw/rtl/qslp_pkg.sv -----
// Shared constants, CORDIC angle table and payload types for the quaternion slerp pipeline.
// No dependencies; qslp_vec, qslp_rot and quaternion_slerp import this package.
package qslp_pkg;

   localparam int CORDIC_STEPS = 24;
   localparam int XY_W         = 34;   // CORDIC x/y datapath, Q.28 with headroom
   localparam int ANGLE_W      = 28;   // CORDIC angle, signed Q.24

   localparam logic signed [ANGLE_W-1:0] ATAN_TAB [CORDIC_STEPS] = '{
      28'sd13176795, 28'sd7778716, 28'sd4110060, 28'sd2086331,
      28'sd1047214,  28'sd524117,  28'sd262123,  28'sd131069,
      28'sd65536,    28'sd32768,   28'sd16384,   28'sd8192,
      28'sd4096,     28'sd2048,    28'sd1024,    28'sd512,
      28'sd256,      28'sd128,     28'sd64,      28'sd32,
      28'sd16,       28'sd8,       28'sd4,       28'sd2
   };

   localparam logic signed [XY_W-1:0] CORDIC_K = 34'sd163008219;   // inverse gain, Q.28
   localparam logic [24:0] HALF_PI            = 25'd26353589;      // pi/2, Q.24
   localparam logic [28:0] ONE_Q28            = 29'd268435456;
   localparam logic [28:0] SIN_FLOOR          = 29'd268435;        // 0.001, Q.28
   localparam logic [16:0] FRAC_ONE           = 17'd65536;

   typedef logic [3:0][15:0] quat_type;    // element 0 is w, then x, y, z
   typedef logic [3:0][31:0] res_type;     // unnormalized result, signed Q.28

   typedef struct packed {
      logic       neg;
      logic [16:0] frac;
      quat_type   s;
      quat_type   g;
   } item_type;

   typedef struct packed {
      logic [28:0] c;
      item_type    item;
   } sq_pl_type;

   typedef struct packed {
      logic     trig;
      item_type item;
   } wt_pl_type;

   typedef struct packed {
      logic    norm;
      res_type r;
   } fin_pl_type;

endpackage

// ----- hw/rtl/qslp_isqrt.sv -----
// Pipelined integer square root, one result bit per stage, with a payload carried alongside.
// Depends on nothing but the clock enable of the surrounding pipeline.
module qslp_isqrt #(
   parameter int W  = 64,
   parameter int PW = 8
) (
   input  logic           clock,
   input  logic           reset,
   input  logic           en,
   input  logic           in_valid,
   input  logic [W-1:0]   in_value,
   input  logic [PW-1:0]  in_pl,
   output logic           out_valid,
   output logic [W/2-1:0] out_root,
   output logic [PW-1:0]  out_pl
);
   localparam int N = W / 2;

   logic [N-1:0]  vld_ff;
   logic [W-1:0]  v_ff  [N];
   logic [W-1:0]  r_ff  [N];
   logic [PW-1:0] pl_ff [N];

   for (genvar k = 0; k < N; k++) begin : g_step
      localparam logic [W:0] BIT = {{W{1'b0}}, 1'b1} << (W - 2 - 2 * k);
      logic [W-1:0]  v_src;
      logic [W-1:0]  r_src;
      logic          vld_src;
      logic [PW-1:0] pl_src;
      logic [W:0]    trial;

      if (k == 0) begin : g_first
         assign v_src   = in_value;
         assign r_src   = '0;
         assign vld_src = in_valid;
         assign pl_src  = in_pl;
      end else begin : g_next
         assign v_src   = v_ff[k-1];
         assign r_src   = r_ff[k-1];
         assign vld_src = vld_ff[k-1];
         assign pl_src  = pl_ff[k-1];
      end

      assign trial = {1'b0, r_src} + BIT;

      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[k] <= 1'b0;
         end else if (en) begin
            vld_ff[k] <= vld_src;
         end
         if (en) begin
            pl_ff[k] <= pl_src;
            if ({1'b0, v_src} >= trial) begin
               v_ff[k] <= v_src - trial[W-1:0];
               r_ff[k] <= (r_src >> 1) + BIT[W-1:0];
            end else begin
               v_ff[k] <= v_src;
               r_ff[k] <= r_src >> 1;
            end
         end
      end
   end

   assign out_valid = vld_ff[N-1];
   assign out_root  = r_ff[N-1][N-1:0];
   assign out_pl    = pl_ff[N-1];

endmodule

// ----- hw/rtl/qslp_vec.sv -----
// Vectoring CORDIC, one micro-rotation per stage: angle of (x, y) in Q.24.
// Depends on qslp_pkg for the angle table and datapath widths.
module qslp_vec #(
   parameter int PW = 8
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              en,
   input  logic                              in_valid,
   input  logic signed [qslp_pkg::XY_W-1:0]  in_x,
   input  logic signed [qslp_pkg::XY_W-1:0]  in_y,
   input  logic [PW-1:0]                     in_pl,
   output logic                              out_valid,
   output logic signed [qslp_pkg::ANGLE_W-1:0] out_angle,
   output logic [PW-1:0]                     out_pl
);
   import qslp_pkg::*;

   logic [CORDIC_STEPS-1:0]    vld_ff;
   logic signed [XY_W-1:0]     x_ff  [CORDIC_STEPS];
   logic signed [XY_W-1:0]     y_ff  [CORDIC_STEPS];
   logic signed [ANGLE_W-1:0]  z_ff  [CORDIC_STEPS];
   logic [PW-1:0]              pl_ff [CORDIC_STEPS];

   for (genvar k = 0; k < CORDIC_STEPS; k++) begin : g_step
      logic signed [XY_W-1:0]    xs;
      logic signed [XY_W-1:0]    ys;
      logic signed [ANGLE_W-1:0] zs;
      logic                      vs;
      logic [PW-1:0]             ps;
      logic signed [XY_W-1:0]    dx;
      logic signed [XY_W-1:0]    dy;

      if (k == 0) begin : g_first
         assign xs = in_x;
         assign ys = in_y;
         assign zs = '0;
         assign vs = in_valid;
         assign ps = in_pl;
      end else begin : g_next
         assign xs = x_ff[k-1];
         assign ys = y_ff[k-1];
         assign zs = z_ff[k-1];
         assign vs = vld_ff[k-1];
         assign ps = pl_ff[k-1];
      end

      assign dx = ys >>> k;
      assign dy = xs >>> k;

      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[k] <= 1'b0;
         end else if (en) begin
            vld_ff[k] <= vs;
         end
         if (en) begin
            pl_ff[k] <= ps;
            // drive y toward zero
            if (ys >= 0) begin
               x_ff[k] <= xs + dx;
               y_ff[k] <= ys - dy;
               z_ff[k] <= zs + ATAN_TAB[k];
            end else begin
               x_ff[k] <= xs - dx;
               y_ff[k] <= ys + dy;
               z_ff[k] <= zs - ATAN_TAB[k];
            end
         end
      end
   end

   assign out_valid = vld_ff[CORDIC_STEPS-1];
   assign out_angle = z_ff[CORDIC_STEPS-1];
   assign out_pl    = pl_ff[CORDIC_STEPS-1];

endmodule

// ----- hw/rtl/qslp_rot.sv -----
// Rotation CORDIC lanes, one micro-rotation per stage: sine of each Q.24 angle in Q.28.
// Depends on qslp_pkg for the angle table, gain constant and widths.
module qslp_rot #(
   parameter int LANES = 3,
   parameter int PW    = 8
) (
   input  logic                                      clock,
   input  logic                                      reset,
   input  logic                                      en,
   input  logic                                      in_valid,
   input  logic [LANES-1:0][qslp_pkg::ANGLE_W-1:0]   in_angle,
   input  logic [PW-1:0]                             in_pl,
   output logic                                      out_valid,
   output logic [LANES-1:0][qslp_pkg::XY_W-1:0]      out_sin,
   output logic [PW-1:0]                             out_pl
);
   import qslp_pkg::*;

   logic [CORDIC_STEPS-1:0]    vld_ff;
   logic [PW-1:0]              pl_ff [CORDIC_STEPS];
   logic signed [XY_W-1:0]     x_ff  [CORDIC_STEPS][LANES];
   logic signed [XY_W-1:0]     y_ff  [CORDIC_STEPS][LANES];
   logic signed [ANGLE_W-1:0]  z_ff  [CORDIC_STEPS][LANES];

   for (genvar k = 0; k < CORDIC_STEPS; k++) begin : g_step
      logic          vs;
      logic [PW-1:0] ps;

      if (k == 0) begin : g_first
         assign vs = in_valid;
         assign ps = in_pl;
      end else begin : g_next
         assign vs = vld_ff[k-1];
         assign ps = pl_ff[k-1];
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[k] <= 1'b0;
         end else if (en) begin
            vld_ff[k] <= vs;
         end
         if (en) begin
            pl_ff[k] <= ps;
         end
      end

      for (genvar l = 0; l < LANES; l++) begin : g_lane
         logic signed [XY_W-1:0]    xs;
         logic signed [XY_W-1:0]    ys;
         logic signed [ANGLE_W-1:0] zs;
         logic signed [XY_W-1:0]    dx;
         logic signed [XY_W-1:0]    dy;

         if (k == 0) begin : g_first
            assign xs = CORDIC_K;
            assign ys = '0;
            assign zs = signed'(in_angle[l]);
         end else begin : g_next
            assign xs = x_ff[k-1][l];
            assign ys = y_ff[k-1][l];
            assign zs = z_ff[k-1][l];
         end

         assign dx = ys >>> k;
         assign dy = xs >>> k;

         always_ff @(posedge clock) begin
            if (en) begin
               // drive residual angle toward zero
               if (zs >= 0) begin
                  x_ff[k][l] <= xs - dx;
                  y_ff[k][l] <= ys + dy;
                  z_ff[k][l] <= zs - ATAN_TAB[k];
               end else begin
                  x_ff[k][l] <= xs + dx;
                  y_ff[k][l] <= ys - dy;
                  z_ff[k][l] <= zs + ATAN_TAB[k];
               end
            end
         end
      end
   end

   for (genvar l = 0; l < LANES; l++) begin : g_out
      assign out_sin[l] = y_ff[CORDIC_STEPS-1][l];
   end

   assign out_valid = vld_ff[CORDIC_STEPS-1];
   assign out_pl    = pl_ff[CORDIC_STEPS-1];

endmodule

// ----- hw/rtl/qslp_div.sv -----
// Pipelined restoring divider, one quotient bit per stage, lanes sharing one divisor.
// Unsigned operands; no package dependency.
module qslp_div #(
   parameter int LANES = 2,
   parameter int NW    = 57,
   parameter int DW    = 29,
   parameter int PW    = 8
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       en,
   input  logic                       in_valid,
   input  logic [LANES-1:0][NW-1:0]   in_num,
   input  logic [DW-1:0]              in_den,
   input  logic [PW-1:0]              in_pl,
   output logic                       out_valid,
   output logic [LANES-1:0][NW-1:0]   out_quo,
   output logic [PW-1:0]              out_pl
);
   logic [NW-1:0] vld_ff;
   logic [DW-1:0] d_ff  [NW];
   logic [PW-1:0] pl_ff [NW];
   logic [NW-1:0] n_ff  [NW][LANES];
   logic [DW-1:0] r_ff  [NW][LANES];

   for (genvar k = 0; k < NW; k++) begin : g_step
      logic          vs;
      logic [PW-1:0] ps;
      logic [DW-1:0] ds;

      if (k == 0) begin : g_first
         assign vs = in_valid;
         assign ps = in_pl;
         assign ds = in_den;
      end else begin : g_next
         assign vs = vld_ff[k-1];
         assign ps = pl_ff[k-1];
         assign ds = d_ff[k-1];
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[k] <= 1'b0;
         end else if (en) begin
            vld_ff[k] <= vs;
         end
         if (en) begin
            pl_ff[k] <= ps;
            d_ff[k]  <= ds;
         end
      end

      for (genvar l = 0; l < LANES; l++) begin : g_lane
         logic [NW-1:0] ns;
         logic [DW-1:0] rs;
         logic [DW:0]   trial;
         logic [DW:0]   diff;
         logic          ge;

         if (k == 0) begin : g_first
            assign ns = in_num[l];
            assign rs = '0;
         end else begin : g_next
            assign ns = n_ff[k-1][l];
            assign rs = r_ff[k-1][l];
         end

         assign trial = {rs, ns[NW-1]};
         assign diff  = trial - {1'b0, ds};
         assign ge    = trial >= {1'b0, ds};

         always_ff @(posedge clock) begin
            if (en) begin
               // shift the next dividend bit out, the quotient bit in
               n_ff[k][l] <= {ns[NW-2:0], ge};
               r_ff[k][l] <= ge ? diff[DW-1:0] : trial[DW-1:0];
            end
         end
      end
   end

   for (genvar l = 0; l < LANES; l++) begin : g_out
      assign out_quo[l] = n_ff[NW-1][l];
   end

   assign out_valid = vld_ff[NW-1];
   assign out_pl    = pl_ff[NW-1];

endmodule

// ----- hw/rtl/quaternion_slerp.sv -----
// Shortest-path quaternion slerp, fixed point. Throughput: one word per cycle while the
// response is not stalled. The pipeline runs through the stages of the two square-root
// units (29 and 32), the vectoring and rotation CORDIC units (24 each) and the two dividers
// (57 and 45), one bit or step per stage. A stalled response freezes the whole pipeline.
// Synchronous reset clears all valid bits and sets norm_floor to 1. Depends on qslp_pkg,
// qslp_isqrt, qslp_vec, qslp_rot, qslp_div.
module quaternion_slerp (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   // start_w, start_x, start_y, start_z, target_w, target_x, target_y, target_z,
   // fraction [144:128], zero fill [151:145]
   input  logic [151:0] req_tdata,
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // out_w, out_x, out_y, out_z
   output logic [63:0]  rsp_tdata,
   input  logic         csr_wr_en,
   input  logic [13:0]  csr_wr_data
);
   import qslp_pkg::*;

   logic adv;
   logic [13:0] norm_floor_ff;

   assign adv        = !rsp_tvalid || rsp_tready;
   assign req_tready = adv;

   always_ff @(posedge clock) begin
      if (reset) begin
         norm_floor_ff <= 14'd1;
      end else if (csr_wr_en) begin
         norm_floor_ff <= csr_wr_data;
      end
   end

   // ---------------- input, dot product, 1 - c^2 ----------------
   logic              v0_ff, v1_ff, v2_ff, v3_ff;
   quat_type          s0_ff, g0_ff, s1_ff, g1_ff;
   logic [16:0]       t0_ff, t1_ff;
   logic signed [31:0] p1_ff [4];
   item_type          it2_ff;
   logic [28:0]       c2_ff;
   sq_pl_type         sq3_ff;
   logic [56:0]       v3_val_ff;

   logic signed [33:0] dot2;
   logic [33:0]        adot2;
   logic [57:0]        csq3;

   always_comb begin
      dot2  = 34'(p1_ff[0]) + 34'(p1_ff[1]) + 34'(p1_ff[2]) + 34'(p1_ff[3]);
      adot2 = (dot2 < 0) ? 34'(-dot2) : 34'(dot2);
      csq3  = 58'(c2_ff) * 58'(c2_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v0_ff <= 1'b0;
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
      end else if (adv) begin
         v0_ff <= req_tvalid;
         v1_ff <= v0_ff;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
      end
      if (adv) begin
         s0_ff <= req_tdata[63:0];
         g0_ff <= req_tdata[127:64];
         t0_ff <= req_tdata[144:128];

         for (int i = 0; i < 4; i++) begin
            p1_ff[i] <= $signed(s0_ff[i]) * $signed(g0_ff[i]);
         end
         s1_ff <= s0_ff;
         g1_ff <= g0_ff;
         t1_ff <= (t0_ff > FRAC_ONE) ? FRAC_ONE : t0_ff;

         it2_ff.neg  <= dot2 < 0;
         it2_ff.frac <= t1_ff;
         it2_ff.s    <= s1_ff;
         it2_ff.g    <= g1_ff;
         c2_ff       <= (adot2 > 34'(ONE_Q28)) ? ONE_Q28 : adot2[28:0];

         sq3_ff.c    <= c2_ff;
         sq3_ff.item <= it2_ff;
         v3_val_ff   <= {1'b1, 56'd0} - csq3[56:0];
      end
   end

   // ---------------- sin(theta) magnitude by square root ----------------
   logic      sq_valid;
   logic [28:0] sq_root;
   sq_pl_type sq_pl;

   qslp_isqrt #(.W(58), .PW($bits(sq_pl_type))) u_isqrt_sin (
      .clock     (clock),
      .reset     (reset),
      .en        (adv),
      .in_valid  (v3_ff),
      .in_value  ({1'b0, v3_val_ff}),
      .in_pl     (sq3_ff),
      .out_valid (sq_valid),
      .out_root  (sq_root),
      .out_pl    (sq_pl)
   );

   // ---------------- theta = atan2(s, c) ----------------
   logic                      vec_valid;
   logic signed [ANGLE_W-1:0] vec_angle;
   item_type                  vec_pl;

   qslp_vec #(.PW($bits(item_type))) u_vec (
      .clock     (clock),
      .reset     (reset),
      .en        (adv),
      .in_valid  (sq_valid),
      .in_x      ({5'd0, sq_pl.c}),
      .in_y      ({5'd0, sq_root}),
      .in_pl     (sq_pl.item),
      .out_valid (vec_valid),
      .out_angle (vec_angle),
      .out_pl    (vec_pl)
   );

   logic        vt1_ff, vt2_ff;
   logic [24:0] theta1_ff, theta2_ff, ang_a2_ff, ang_b2_ff;
   item_type    it_t1_ff, it_t2_ff;
   logic [41:0] prod_a, prod_b;

   always_comb begin
      prod_a = 42'(theta1_ff) * 42'(FRAC_ONE - it_t1_ff.frac);
      prod_b = 42'(theta1_ff) * 42'(it_t1_ff.frac);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vt1_ff <= 1'b0;
         vt2_ff <= 1'b0;
      end else if (adv) begin
         vt1_ff <= vec_valid;
         vt2_ff <= vt1_ff;
      end
      if (adv) begin
         priority if (vec_angle < 0) begin
            theta1_ff <= '0;
         end else if (vec_angle > $signed({3'd0, HALF_PI})) begin
            theta1_ff <= HALF_PI;
         end else begin
            theta1_ff <= vec_angle[24:0];
         end
         it_t1_ff  <= vec_pl;

         theta2_ff <= theta1_ff;
         ang_a2_ff <= prod_a[40:16];
         ang_b2_ff <= prod_b[40:16];
         it_t2_ff  <= it_t1_ff;
      end
   end

   // ---------------- sin(theta), sin((1-t)theta), sin(t theta) ----------------
   logic                       rot_valid;
   logic [2:0][XY_W-1:0]       rot_sin;
   item_type                   rot_pl;

   qslp_rot #(.LANES(3), .PW($bits(item_type))) u_rot (
      .clock     (clock),
      .reset     (reset),
      .en        (adv),
      .in_valid  (vt2_ff),
      .in_angle  ({{3'd0, ang_b2_ff}, {3'd0, ang_a2_ff}, {3'd0, theta2_ff}}),
      .in_pl     (it_t2_ff),
      .out_valid (rot_valid),
      .out_sin   (rot_sin),
      .out_pl    (rot_pl)
   );

   logic        vs1_ff;
   logic [28:0] sin1_ff [3];
   wt_pl_type   wt1_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         vs1_ff <= 1'b0;
      end else if (adv) begin
         vs1_ff <= rot_valid;
      end
      if (adv) begin
         for (int l = 0; l < 3; l++) begin
            priority if ($signed(rot_sin[l]) < 0) begin
               sin1_ff[l] <= '0;
            end else if ($signed(rot_sin[l]) > $signed({5'd0, ONE_Q28})) begin
               sin1_ff[l] <= ONE_Q28;
            end else begin
               sin1_ff[l] <= rot_sin[l][28:0];
            end
         end
         wt1_ff.trig <= $signed(rot_sin[0]) > $signed({5'd0, SIN_FLOOR});
         wt1_ff.item <= rot_pl;
      end
   end

   // ---------------- trig weights ----------------
   logic              d2_valid;
   logic [1:0][56:0]  d2_quo;
   wt_pl_type         d2_pl;

   qslp_div #(.LANES(2), .NW(57), .DW(29), .PW($bits(wt_pl_type))) u_div_weight (
      .clock     (clock),
      .reset     (reset),
      .en        (adv),
      .in_valid  (vs1_ff),
      .in_num    ({{sin1_ff[2], 28'd0}, {sin1_ff[1], 28'd0}}),
      .in_den    (sin1_ff[0]),
      .in_pl     (wt1_ff),
      .out_valid (d2_valid),
      .out_quo   (d2_quo),
      .out_pl    (d2_pl)
   );

   // ---------------- weighted sum ----------------
   logic               vw_ff, vm_ff, vr_ff, vq_ff, va1_ff, va2_ff;
   logic [38:0]        scale_ff, inv_ff;
   item_type           it_w_ff;
   logic signed [55:0] ps_ff [4];
   logic signed [55:0] pg_ff [4];
   logic               neg_m_ff;
   res_type            r_r_ff, r_q_ff, r_a1_ff, r_a2_ff;
   logic [60:0]        sq_q_ff [4];
   logic [61:0]        sum01_ff, sum23_ff;
   logic [62:0]        acc_ff;

   logic signed [56:0] wsum [4];
   logic signed [56:0] wsh  [4];
   logic signed [63:0] rsq  [4];

   always_comb begin
      for (int i = 0; i < 4; i++) begin
         wsum[i] = neg_m_ff ? 57'(ps_ff[i]) - 57'(pg_ff[i]) : 57'(ps_ff[i]) + 57'(pg_ff[i]);
         wsh[i]  = wsum[i] >>> 14;
         rsq[i]  = 64'($signed(r_r_ff[i])) * 64'($signed(r_r_ff[i]));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vw_ff  <= 1'b0;
         vm_ff  <= 1'b0;
         vr_ff  <= 1'b0;
         vq_ff  <= 1'b0;
         va1_ff <= 1'b0;
         va2_ff <= 1'b0;
      end else if (adv) begin
         vw_ff  <= d2_valid;
         vm_ff  <= vw_ff;
         vr_ff  <= vm_ff;
         vq_ff  <= vr_ff;
         va1_ff <= vq_ff;
         va2_ff <= va1_ff;
      end
      if (adv) begin
         // fall back to linear weights for a near-zero angle
         if (d2_pl.trig) begin
            scale_ff <= d2_quo[0][38:0];
            inv_ff   <= d2_quo[1][38:0];
         end else begin
            scale_ff <= {10'd0, FRAC_ONE - d2_pl.item.frac, 12'd0};
            inv_ff   <= {10'd0, d2_pl.item.frac, 12'd0};
         end
         it_w_ff <= d2_pl.item;

         for (int i = 0; i < 4; i++) begin
            ps_ff[i] <= 56'($signed({1'b0, scale_ff})) * 56'($signed(it_w_ff.s[i]));
            pg_ff[i] <= 56'($signed({1'b0, inv_ff})) * 56'($signed(it_w_ff.g[i]));
         end
         neg_m_ff <= it_w_ff.neg;

         for (int i = 0; i < 4; i++) begin
            priority if (wsh[i] > 57'sd1073741824) begin
               r_r_ff[i] <= 32'sd1073741824;
            end else if (wsh[i] < -57'sd1073741824) begin
               r_r_ff[i] <= -32'sd1073741824;
            end else begin
               r_r_ff[i] <= wsh[i][31:0];
            end
         end

         for (int i = 0; i < 4; i++) begin
            sq_q_ff[i] <= rsq[i][60:0];
         end
         r_q_ff <= r_r_ff;

         sum01_ff <= {1'b0, sq_q_ff[0]} + {1'b0, sq_q_ff[1]};
         sum23_ff <= {1'b0, sq_q_ff[2]} + {1'b0, sq_q_ff[3]};
         r_a1_ff  <= r_q_ff;

         acc_ff  <= {1'b0, sum01_ff} + {1'b0, sum23_ff};
         r_a2_ff <= r_a1_ff;
      end
   end

   // ---------------- magnitude ----------------
   logic        mg_valid;
   logic [31:0] mg_root;
   res_type     mg_pl;

   qslp_isqrt #(.W(64), .PW($bits(res_type))) u_isqrt_mag (
      .clock     (clock),
      .reset     (reset),
      .en        (adv),
      .in_valid  (va2_ff),
      .in_value  ({1'b0, acc_ff}),
      .in_pl     (r_a2_ff),
      .out_valid (mg_valid),
      .out_root  (mg_root),
      .out_pl    (mg_pl)
   );

   logic             vn_ff;
   logic [3:0][44:0] num_n_ff;
   logic [31:0]      mag_n_ff;
   fin_pl_type       fin_n_ff;
   logic [31:0]      absr [4];

   always_comb begin
      for (int i = 0; i < 4; i++) begin
         absr[i] = $signed(mg_pl[i]) < 0 ? 32'(-$signed(mg_pl[i])) : mg_pl[i];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vn_ff <= 1'b0;
      end else if (adv) begin
         vn_ff <= mg_valid;
      end
      if (adv) begin
         for (int i = 0; i < 4; i++) begin
            num_n_ff[i] <= {absr[i][30:0], 14'd0};
         end
         mag_n_ff      <= mg_root;
         fin_n_ff.norm <= mg_root > {4'd0, norm_floor_ff, 14'd0};
         fin_n_ff.r    <= mg_pl;
      end
   end

   // ---------------- normalize ----------------
   logic             d4_valid;
   logic [3:0][44:0] d4_quo;
   fin_pl_type       d4_pl;

   qslp_div #(.LANES(4), .NW(45), .DW(32), .PW($bits(fin_pl_type))) u_div_norm (
      .clock     (clock),
      .reset     (reset),
      .en        (adv),
      .in_valid  (vn_ff),
      .in_num    (num_n_ff),
      .in_den    (mag_n_ff),
      .in_pl     (fin_n_ff),
      .out_valid (d4_valid),
      .out_quo   (d4_quo),
      .out_pl    (d4_pl)
   );

   logic             vo_ff;
   logic [3:0][15:0] out_ff;
   logic [3:0][15:0] out_in;
   logic signed [31:0] rsh [4];

   always_comb begin
      for (int i = 0; i < 4; i++) begin
         rsh[i] = $signed(d4_pl.r[i]) >>> 14;
         if (d4_pl.norm) begin
            if ($signed(d4_pl.r[i]) < 0) begin
               out_in[i] = (d4_quo[i] > 45'd32768) ? 16'h8000 : 16'd0 - d4_quo[i][15:0];
            end else begin
               out_in[i] = (d4_quo[i] > 45'd32767) ? 16'h7fff : d4_quo[i][15:0];
            end
         end else begin
            priority if (rsh[i] > 32'sd32767) begin
               out_in[i] = 16'h7fff;
            end else if (rsh[i] < -32'sd32768) begin
               out_in[i] = 16'h8000;
            end else begin
               out_in[i] = rsh[i][15:0];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vo_ff <= 1'b0;
      end else if (adv) begin
         vo_ff <= d4_valid;
      end
      if (adv) begin
         out_ff <= out_in;
      end
   end

   assign rsp_tvalid = vo_ff;
   assign rsp_tdata  = out_ff;

   // ---------------- checks ----------------
   // linear weights always sum to one
   a_linear_sum: assert property (@(posedge clock) disable iff (reset)
      (adv && d2_valid && !d2_pl.trig) |=>
         ({1'b0, scale_ff} + {1'b0, inv_ff} == 40'd268435456))
      else $error("linear weights do not sum to one");

   // no component exceeds the magnitude it is divided by
   a_norm_bound: assert property (@(posedge clock) disable iff (reset)
      (d4_valid && d4_pl.norm) |->
         (d4_quo[0] <= 45'd16384 && d4_quo[1] <= 45'd16384 &&
          d4_quo[2] <= 45'd16384 && d4_quo[3] <= 45'd16384))
      else $error("normalized component above one");

   a_reset_idle: assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("response valid after reset");

endmodule

// ----- dv/quaternion_slerp_test.sv -----
// Self-checking testbench for the quaternion_slerp stream block.
// Carries its own fixed-point slerp predictor; needs only the RTL and qslp_pkg.
module quaternion_slerp_test;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int    LIMIT_CYCLES = 600000;
   localparam int    LATENCY      = 226;
   localparam longint ONE28       = 64'sd268435456;
   localparam longint HALF_PI24   = 64'sd26353589;
   localparam longint GAIN_INV28  = 64'sd163008219;
   localparam longint SIN_MIN28   = 64'sd268435;
   localparam longint ARC_TAB [24] = '{
      13176795, 7778716, 4110060, 2086331, 1047214, 524117, 262123, 131069,
      65536, 32768, 16384, 8192, 4096, 2048, 1024, 512,
      256, 128, 64, 32, 16, 8, 4, 2
   };

   typedef struct {
      logic [151:0] word;
      bit           known;
      logic [63:0]  result;
   } slerp_row_type;

   logic         clock = 0;
   logic         reset = 1;
   logic         req_tvalid = 0;
   logic         req_tready;
   logic [151:0] req_tdata = '0;
   logic         rsp_tvalid;
   logic         rsp_tready = 0;
   logic [63:0]  rsp_tdata;
   logic         csr_wr_en = 0;
   logic [13:0]  csr_wr_data = '0;

   logic [13:0]  floor_model = 14'd1;
   logic [63:0]  expected_quats [$];
   logic [63:0]  last_rsp = '0;
   bit           req_taken = 0;
   int           error_count = 0;
   int           cycle_count = 0;
   int           send_idle_pct = 0;
   int           recv_stall_pct = 0;
   bit           hold_start = 0;
   bit           hold_rsp = 0;
   slerp_row_type directed_rows [$];

   quaternion_slerp i_dut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready), .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata),
      .csr_wr_en(csr_wr_en), .csr_wr_data(csr_wr_data)
   );

   initial begin
      forever begin
         #5 clock = ~clock;
      end
   end

   function automatic longint unsigned int_sqrt(longint unsigned v);
      longint unsigned r = 0;
      longint unsigned b = 64'h4000_0000_0000_0000;
      while (b > v) b = b >> 2;
      while (b != 0) begin
         if (v >= r + b) begin
            v = v - (r + b);
            r = (r >> 1) + b;
         end else begin
            r = r >> 1;
         end
         b = b >> 2;
      end
      return r;
   endfunction

   function automatic longint arc_of(longint y, longint x);
      longint z = 0;
      longint dx, dy;
      for (int i = 0; i < 24; i++) begin
         dx = y >>> i;
         dy = x >>> i;
         if (y >= 0) begin
            x = x + dx; y = y - dy; z = z + ARC_TAB[i];
         end else begin
            x = x - dx; y = y + dy; z = z - ARC_TAB[i];
         end
      end
      if (z < 0) z = 0;
      if (z > HALF_PI24) z = HALF_PI24;
      return z;
   endfunction

   function automatic longint sine_of(longint z);
      longint x = GAIN_INV28;
      longint y = 0;
      longint dx, dy;
      for (int i = 0; i < 24; i++) begin
         dx = y >>> i;
         dy = x >>> i;
         if (z >= 0) begin
            x = x - dx; y = y + dy; z = z - ARC_TAB[i];
         end else begin
            x = x + dx; y = y - dy; z = z + ARC_TAB[i];
         end
      end
      if (y < 0) y = 0;
      if (y > ONE28) y = ONE28;
      return y;
   endfunction

   function automatic logic [63:0] slerp_of(logic [151:0] word, logic [13:0] nfloor);
      longint s [4];
      longint g [4];
      longint r [4];
      longint dot = 0;
      longint c, sn, theta, tf, scale, inv, sth, sa, sb, v, o;
      longint unsigned acc = 0;
      longint unsigned mag;
      bit neg;
      logic [63:0] res;
      for (int i = 0; i < 4; i++) begin
         s[i] = longint'($signed(word[16*i +: 16]));
         g[i] = longint'($signed(word[64 + 16*i +: 16]));
         dot = dot + s[i] * g[i];
      end
      tf = longint'(word[144:128]);
      if (tf > 65536) tf = 65536;
      neg = dot < 0;
      c = neg ? -dot : dot;
      if (c > ONE28) c = ONE28;
      sn = longint'(int_sqrt((64'd1 << 56) - longint'(c * c)));
      theta = arc_of(sn, c);
      sth = sine_of(theta);
      if (sth > SIN_MIN28) begin
         sa = sine_of((theta * (65536 - tf)) >>> 16);
         sb = sine_of((theta * tf) >>> 16);
         scale = (sa <<< 28) / sth;
         inv = (sb <<< 28) / sth;
      end else begin
         scale = (65536 - tf) <<< 12;
         inv = tf <<< 12;
      end
      for (int i = 0; i < 4; i++) begin
         v = neg ? scale * s[i] - inv * g[i] : scale * s[i] + inv * g[i];
         v = v >>> 14;
         if (v > (64'sd1 <<< 30)) v = 64'sd1 <<< 30;
         if (v < -(64'sd1 <<< 30)) v = -(64'sd1 <<< 30);
         r[i] = v;
         acc = acc + longint'(v * v);
      end
      mag = int_sqrt(acc);
      for (int i = 0; i < 4; i++) begin
         if (mag > (longint'(nfloor) << 14)) o = (r[i] * 16384) / longint'(mag);
         else o = r[i] >>> 14;
         if (o > 32767) o = 32767;
         if (o < -32768) o = -32768;
         res[16*i +: 16] = o[15:0];
      end
      return res;
   endfunction

   function automatic logic [151:0] pack_word(logic [63:0] st, logic [63:0] tg,
                                              logic [16:0] frac);
      return {7'd0, frac, tg, st};
   endfunction

   function automatic logic [63:0] quat(int w, int x, int y, int z);
      return {z[15:0], y[15:0], x[15:0], w[15:0]};
   endfunction

   task automatic report_mismatch(string what, logic [15:0] got, logic [15:0] want);
      $display("mismatch %s: got %0d expected %0d at cycle %0d",
               what, $signed(got), $signed(want), cycle_count);
      error_count++;
   endtask

   // Handshake monitor: all decisions use pre-edge values.
   always @(posedge clock) begin
      logic [63:0] want;
      string names [4];
      names = '{"out_w", "out_x", "out_y", "out_z"};
      cycle_count++;
      if (cycle_count > LIMIT_CYCLES) begin
         $display("timeout after %0d cycles", cycle_count);
         $display("CHECKS FAILED");
         $finish;
      end else begin
         req_taken = 0;
         if (reset) begin
            floor_model = 14'd1;
         end else begin
            if (csr_wr_en) floor_model = csr_wr_data;
            if (req_tvalid && req_tready) begin
               req_taken = 1;
               expected_quats.push_back(slerp_of(req_tdata, floor_model));
            end
            if (rsp_tvalid && rsp_tready) begin
               last_rsp = rsp_tdata;
               if (expected_quats.size() == 0) begin
                  $display("unexpected response word at cycle %0d", cycle_count);
                  error_count++;
               end else begin
                  want = expected_quats.pop_front();
                  for (int i = 0; i < 4; i++)
                     if (rsp_tdata[16*i +: 16] !== want[16*i +: 16])
                        report_mismatch(names[i], rsp_tdata[16*i +: 16], want[16*i +: 16]);
               end
            end
         end
      end
   end

   always @(negedge clock) begin
      rsp_tready <= !hold_rsp && ($urandom_range(99) >= recv_stall_pct);
   end

   // Long receiver hold-off, counted here so the sender keeps offering.
   initial begin
      forever begin
         @(posedge clock);
         if (hold_start) begin
            hold_rsp = 1;
            repeat (900) @(posedge clock);
            hold_rsp = 0;
            hold_start = 0;
         end
      end
   end

   task automatic send_word(logic [151:0] word);
      if (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 0;
         do @(negedge clock); while ($urandom_range(99) < send_idle_pct);
      end
      req_tvalid <= 1;
      req_tdata <= word;
      do @(negedge clock); while (!req_taken);
   endtask

   task automatic drain();
      if (req_tvalid) req_tvalid <= 0;
      while (expected_quats.size() != 0) @(negedge clock);
   endtask

   task automatic write_floor(logic [13:0] value);
      csr_wr_en <= 1;
      csr_wr_data <= value;
      @(negedge clock);
      csr_wr_en <= 0;
      @(negedge clock);
   endtask

   function automatic logic [63:0] random_quat();
      logic [63:0] q;
      case ($urandom_range(3))
         0: q = {$urandom, $urandom};
         1: q = quat($urandom_range(32767) - 16384, $urandom_range(32767) - 16384,
                     $urandom_range(32767) - 16384, $urandom_range(32767) - 16384);
         2: q = quat($urandom_range(16384), $urandom_range(400) - 200,
                     $urandom_range(400) - 200, $urandom_range(9000) - 4500);
         default: q = quat($urandom_range(3) - 2, $urandom_range(3) - 2, 0,
                           $urandom_range(65535) - 32768);
      endcase
      return q;
   endfunction

   function automatic logic [151:0] random_item();
      logic [63:0] st, tg;
      logic [16:0] frac;
      int noise;
      st = random_quat();
      noise = $urandom_range(6) - 3;
      case ($urandom_range(9))
         0, 1: tg = random_quat();
         2, 3, 4: tg = quat($signed(st[15:0]) + noise, $signed(st[31:16]) - noise,
                            $signed(st[47:32]), $signed(st[63:48]) + noise);
         5, 6: tg = quat(-$signed(st[15:0]), -$signed(st[31:16]) + noise,
                         -$signed(st[47:32]), -$signed(st[63:48]));
         7: tg = st;
         default: tg = {$urandom, $urandom};
      endcase
      if ($urandom_range(7) == 0) frac = 17'($urandom);
      else frac = 17'($urandom_range(65536));
      return pack_word(st, tg, frac);
   endfunction

   task automatic add_row(logic [63:0] st, logic [63:0] tg, logic [16:0] frac,
                          bit known = 0, logic [63:0] result = '0);
      slerp_row_type row;
      row.word = pack_word(st, tg, frac);
      row.known = known;
      row.result = result;
      directed_rows.push_back(row);
   endtask

   task automatic run_random(int count);
      for (int n = 0; n < count; n++) send_word(random_item());
   endtask

   initial begin
      logic [63:0] unit_w;
      unit_w = quat(16384, 0, 0, 0);
      add_row('0, '0, 17'd0, 1, '0);
      add_row('0, '0, 17'd65536, 1, '0);
      add_row(unit_w, unit_w, 17'd0);
      add_row(unit_w, unit_w, 17'd32768);
      add_row(unit_w, unit_w, 17'd65536);
      add_row(unit_w, quat(0, 16384, 0, 0), 17'd32768);          // dot exactly zero
      add_row(unit_w, quat(-16384, 0, 0, 0), 17'd16384);         // opposite sign
      add_row(quat(32767, 32767, 32767, 32767), quat(32767, 32767, 32767, 32767),
              17'd40000);                                        // dot above one
      add_row(quat(-32768, -32768, -32768, -32768), quat(32767, 32767, 32767, 32767),
              17'd1);                                            // dot below minus one
      add_row(quat(-32768, 32767, -32768, 32767), quat(32767, -32768, 32767, -32768),
              17'd65535);
      add_row(unit_w, quat(11585, 11585, 0, 0), 17'h1FFFF);      // fraction above one
      add_row(unit_w, quat(11585, 0, 11585, 0), 17'd65537);
      add_row(quat(1, 0, 0, 0), quat(1, 0, 0, 0), 17'd30000);    // tiny magnitude
      add_row(quat(2, -1, 0, 1), quat(0, 1, -2, 0), 17'd50000);
      add_row(quat(16384, 1, 0, 0), quat(16384, 0, 1, 0), 17'd20000); // small angle
      add_row(quat(8192, 8192, 8192, 8192), quat(8192, -8192, 8192, -8192), 17'd32768);
      add_row(quat(0, 0, 0, 32767), quat(0, 0, 0, -32768), 17'd0);

      repeat (8) @(negedge clock);
      reset <= 0;
      @(negedge clock);

      foreach (directed_rows[i]) begin
         send_word(directed_rows[i].word);
         if (directed_rows[i].known) begin
            drain();
            for (int k = 0; k < 4; k++)
               if (last_rsp[16*k +: 16] !== directed_rows[i].result[16*k +: 16])
                  report_mismatch("typed row", last_rsp[16*k +: 16],
                                  directed_rows[i].result[16*k +: 16]);
         end
      end
      drain();

      // Phase: no idling, floor at zero.
      write_floor(14'd0);
      send_idle_pct = 0; recv_stall_pct = 0;
      run_random(240);
      drain();

      // Phase: sender idle, floor at its top.
      write_floor(14'd16383);
      send_idle_pct = 64; recv_stall_pct = 0;
      run_random(240);
      drain();

      // Phase: receiver stalling, random floor.
      write_floor(14'($urandom_range(16383)));
      send_idle_pct = 0; recv_stall_pct = 64;
      run_random(240);
      drain();

      // Phase: both idle lightly, long receiver hold-off to back up the pipeline.
      write_floor(14'($urandom_range(40)));
      send_idle_pct = 8; recv_stall_pct = 8;
      run_random(60);
      hold_start = 1;
      run_random(260);
      drain();
      write_floor(14'd1);
      send_idle_pct = 8; recv_stall_pct = 8;
      run_random(80);
      drain();

      repeat (LATENCY + 50) @(negedge clock);
      if (error_count == 0 && expected_quats.size() == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule

// ----- files.f -----
hw/rtl/qslp_pkg.sv
hw/rtl/qslp_isqrt.sv
hw/rtl/qslp_vec.sv
hw/rtl/qslp_rot.sv
hw/rtl/qslp_div.sv
hw/rtl/quaternion_slerp.sv
dv/quaternion_slerp_test.sv
